>>> rtl/core/sdhe_pkg.sv
// ----------------------------------------------------------------------------
// sdhe_pkg: shared constants for the SD card SPI host engine
// Transaction kinds, status codes, card types, command codes and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package sdhe_pkg;

   localparam int BLOCK_BYTES      = 512;
   localparam int BLOCK_AW         = 9;
   localparam int DEF_IDLE_CLOCK_BYTES = 10;
   localparam int DEF_CMD0_RETRIES     = 20;
   localparam int DEF_R1_POLL_LIMIT    = 31;
   localparam int DEF_TOKEN_WAIT_LIMIT = 65535;
   localparam int DEF_ACMD41_RETRIES   = 65534;

   // transaction kinds
   localparam logic [2:0] KIND_INIT  = 3'd0;
   localparam logic [2:0] KIND_READ  = 3'd1;
   localparam logic [2:0] KIND_WRITE = 3'd2;
   localparam logic [2:0] KIND_LOAD  = 3'd3;
   localparam logic [2:0] KIND_REPLY = 3'd4;

   // completion status
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_IDLE   = 3'd1;
   localparam logic [2:0] ST_INIT_FAIL = 3'd2;
   localparam logic [2:0] ST_CMD_REJ   = 3'd3;
   localparam logic [2:0] ST_TOKEN_TO  = 3'd4;
   localparam logic [2:0] ST_WRITE_ERR = 3'd5;

   // card types
   localparam logic [1:0] CARD_UNKNOWN = 2'd0;
   localparam logic [1:0] CARD_SDSC_V2 = 2'd1;
   localparam logic [1:0] CARD_SDHC_V2 = 2'd2;

   // command indexes
   localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
   localparam logic [5:0] CMD_SEND_IF    = 6'd8;
   localparam logic [5:0] CMD_READ_BLK   = 6'd17;
   localparam logic [5:0] CMD_SET_COUNT  = 6'd23;
   localparam logic [5:0] CMD_WRITE_BLK  = 6'd24;
   localparam logic [5:0] CMD_SD_OP_COND = 6'd41;
   localparam logic [5:0] CMD_APP        = 6'd55;
   localparam logic [5:0] CMD_READ_OCR   = 6'd58;

   localparam logic [7:0] CRC_CMD0  = 8'h95;
   localparam logic [7:0] CRC_CMD8  = 8'h87;
   localparam logic [7:0] CRC_DUMMY = 8'h01;
   localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
   localparam logic [31:0] ARG_HCS     = 32'h4000_0000;
   localparam logic [7:0] DATA_TOKEN   = 8'hFE;
   localparam logic [7:0] IDLE_BYTE    = 8'hFF;
   localparam logic [4:0] DRESP_OK     = 5'h05;

endpackage

`default_nettype wire

>>> rtl/core/sdhe_ram.sv
// ----------------------------------------------------------------------------
// sdhe_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module sdhe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/sd_card_spi_host_engine.sv
// ----------------------------------------------------------------------------
// sd_card_spi_host_engine: SD card host in SPI mode, byte-level sequencer
// Runs init, single block read and single block write one SPI byte at a time.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser carries the kind (start init, start read, start write,
//   load write byte, card reply byte); tdata carries sector, data byte and
//   buffer index. Each start, and each card reply while an operation runs,
//   yields one rsp transaction naming the next byte to shift out plus chip
//   select, clock speed, read data and completion status. Loads, starts while
//   busy, replies while idle and unknown kinds yield no rsp transaction.
//   Each accepted transaction loads its result at the accepting edge (one
//   register stage). One req transaction per cycle while req_tready is high;
//   the only memory is the 512-byte write buffer (one write, one registered
//   read port), read during the same cycle that loads the result register.
//   req_tready stays high while the result register is empty or being taken,
//   so a stalled rsp side holds the pending result and blocks new requests.
//   Reset returns to idle, unknown card type, slow clock; the write buffer
//   keeps no reset and must be loaded before a write uses it.
// ----------------------------------------------------------------------------
`default_nettype none

module sd_card_spi_host_engine #(
   parameter int IDLE_CLOCK_BYTES = sdhe_pkg::DEF_IDLE_CLOCK_BYTES,
   parameter int CMD0_RETRIES     = sdhe_pkg::DEF_CMD0_RETRIES,
   parameter int R1_POLL_LIMIT    = sdhe_pkg::DEF_R1_POLL_LIMIT,
   parameter int TOKEN_WAIT_LIMIT = sdhe_pkg::DEF_TOKEN_WAIT_LIMIT,
   parameter int ACMD41_RETRIES   = sdhe_pkg::DEF_ACMD41_RETRIES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [31:0] sector, [39:32] data_byte, [48:40] byte_index, [55:49] zero
   input  wire logic [55:0] req_tdata,
   // [2:0] kind
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [0] tx_valid, [8:1] tx_byte, [9] chip_select_n, [10] fast_clock,
   // [11] read_valid, [19:12] read_byte, [20] done_res, [23:21] status,
   // [25:24] card_type, [31:26] zero
   output logic      [31:0] rsp_tdata
);

   typedef enum logic [4:0] {
      P_IDLE, P_CLK, P_CMD0, P_CMD0_DS, P_CMD8, P_ACMD55, P_ACMD41, P_CMD58,
      P_OCR, P_OCR_DS, P_CMD17, P_TOKEN, P_RDATA, P_RCRC, P_W55, P_W23, P_W24,
      P_WSEND, P_BUSY, P_FINISH
   } phase_type;

   // state
   phase_type   phase_ff, phase_in;
   logic [15:0] retry_ff, retry_in;
   logic [9:0]  bcount_ff, bcount_in;
   logic [7:0]  last_r1_ff, last_r1_in;
   logic [1:0]  det_type_ff, det_type_in;
   logic [31:0] card_addr_ff, card_addr_in;
   logic        init_ok_ff, init_ok_in;
   logic        fast_ff, fast_in;
   logic        op_init_ff, op_init_in;
   logic        ccs_ff, ccs_in;
   logic [2:0]  end_st_ff, end_st_in;
   logic        cmd_busy_ff, cmd_busy_in;
   logic [2:0]  cmd_pos_ff, cmd_pos_in;
   logic [7:0]  cmd_polls_ff, cmd_polls_in;
   logic [5:0]  cmd_code_ff, cmd_code_in;
   logic [31:0] cmd_arg_ff, cmd_arg_in;
   logic [7:0]  cmd_crc_ff, cmd_crc_in;

   // result register
   logic        rsp_valid_ff;
   logic        txv_ff, cs_ff, fastq_ff, rdv_ff, done_ff, use_ram_ff;
   logic [7:0]  tx_ff, rdb_ff;
   logic [2:0]  st_ff;
   logic [1:0]  ctype_ff;

   // request fields
   logic [2:0]  kind;
   logic [31:0] sector;
   logic [7:0]  dbyte;
   logic [8:0]  bidx;
   logic        accept;

   // result of this transaction
   logic        o_valid, o_txv, o_cs, o_rdv, o_done, o_use_ram;
   logic [7:0]  o_tx, o_rdb;
   logic [2:0]  o_st;
   logic [8:0]  ram_raddr;
   logic [7:0]  ram_q;

   // command launch and finish helpers
   logic        do_cmd, do_fin;
   logic [5:0]  dc_code;
   logic [31:0] dc_arg;
   logic [7:0]  dc_crc;
   phase_type   dc_next;
   logic [2:0]  fin_st;
   logic [9:0]  bc_inc;
   logic [9:0]  wpos;

   assign kind   = req_tuser;
   assign sector = req_tdata[31:0];
   assign dbyte  = req_tdata[39:32];
   assign bidx   = req_tdata[48:40];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign bc_inc     = bcount_ff + 10'd1;

   sdhe_ram #(
      .WIDTH (8),
      .DEPTH (sdhe_pkg::BLOCK_BYTES)
   ) u_wbuf (
      .clock   (clock),
      .wr_en   (accept && (kind == sdhe_pkg::KIND_LOAD)),
      .wr_addr (bidx),
      .wr_data (dbyte),
      .rd_en   (accept && o_valid && o_use_ram),
      .rd_addr (ram_raddr),
      .rd_data (ram_q)
   );

   always_comb begin
      phase_in     = phase_ff;
      retry_in     = retry_ff;
      bcount_in    = bcount_ff;
      last_r1_in   = last_r1_ff;
      det_type_in  = det_type_ff;
      card_addr_in = card_addr_ff;
      init_ok_in   = init_ok_ff;
      fast_in      = fast_ff;
      op_init_in   = op_init_ff;
      ccs_in       = ccs_ff;
      end_st_in    = end_st_ff;
      cmd_busy_in  = cmd_busy_ff;
      cmd_pos_in   = cmd_pos_ff;
      cmd_polls_in = cmd_polls_ff;
      cmd_code_in  = cmd_code_ff;
      cmd_arg_in   = cmd_arg_ff;
      cmd_crc_in   = cmd_crc_ff;

      o_valid   = 1'b0;
      o_txv     = 1'b1;
      o_tx      = sdhe_pkg::IDLE_BYTE;
      o_cs      = 1'b0;
      o_rdv     = 1'b0;
      o_rdb     = 8'd0;
      o_done    = 1'b0;
      o_st      = sdhe_pkg::ST_OK;
      o_use_ram = 1'b0;
      ram_raddr = '0;
      wpos      = '0;

      do_cmd  = 1'b0;
      dc_code = sdhe_pkg::CMD_APP;
      dc_arg  = '0;
      dc_crc  = sdhe_pkg::CRC_DUMMY;
      dc_next = P_IDLE;
      do_fin  = 1'b0;
      fin_st  = sdhe_pkg::ST_OK;

      unique case (kind)
         sdhe_pkg::KIND_INIT: begin
            if (phase_ff == P_IDLE) begin
               op_init_in  = 1'b1;
               fast_in     = 1'b0;
               det_type_in = sdhe_pkg::CARD_UNKNOWN;
               init_ok_in  = 1'b0;
               bcount_in   = 10'd1;
               phase_in    = P_CLK;
               o_valid     = 1'b1;
               o_cs        = 1'b1;
            end
         end
         sdhe_pkg::KIND_READ, sdhe_pkg::KIND_WRITE: begin
            if (phase_ff == P_IDLE) begin
               op_init_in   = 1'b0;
               card_addr_in = (det_type_ff == sdhe_pkg::CARD_SDHC_V2) ? sector
                                                                      : {sector[22:0], 9'd0};
               do_cmd = 1'b1;
               if (kind == sdhe_pkg::KIND_READ) begin
                  dc_code = sdhe_pkg::CMD_READ_BLK;
                  dc_arg  = card_addr_in;
                  dc_next = P_CMD17;
               end else begin
                  dc_next = P_W55;
               end
            end
         end
         sdhe_pkg::KIND_REPLY: begin
            if (phase_ff != P_IDLE && cmd_busy_ff) begin
               // command frame out, then poll for R1
               if (cmd_pos_ff != 3'd7) begin
                  cmd_pos_in = cmd_pos_ff + 3'd1;
                  o_valid    = 1'b1;
                  unique case (cmd_pos_in)
                     3'd1:    o_tx = {2'b01, cmd_code_ff};
                     3'd2:    o_tx = cmd_arg_ff[31:24];
                     3'd3:    o_tx = cmd_arg_ff[23:16];
                     3'd4:    o_tx = cmd_arg_ff[15:8];
                     3'd5:    o_tx = cmd_arg_ff[7:0];
                     3'd6:    o_tx = cmd_crc_ff;
                     default: o_tx = sdhe_pkg::IDLE_BYTE;
                  endcase
               end else if (dbyte[7] && (cmd_polls_ff < 8'(R1_POLL_LIMIT))) begin
                  cmd_polls_in = cmd_polls_ff + 8'd1;
                  o_valid      = 1'b1;
               end else begin
                  cmd_busy_in = 1'b0;
                  last_r1_in  = dbyte;
                  unique case (phase_ff)
                     P_CMD0: begin
                        phase_in = P_CMD0_DS;
                        o_valid  = 1'b1;
                        o_cs     = 1'b1;
                     end
                     P_CMD8: begin
                        if (dbyte == 8'h01) begin
                           retry_in = 16'(ACMD41_RETRIES);
                           do_cmd   = 1'b1;
                           dc_next  = P_ACMD55;
                        end else begin
                           init_ok_in = 1'b0;
                           do_fin     = 1'b1;
                           fin_st     = sdhe_pkg::ST_INIT_FAIL;
                        end
                     end
                     P_ACMD55: begin
                        do_cmd  = 1'b1;
                        dc_code = sdhe_pkg::CMD_SD_OP_COND;
                        dc_arg  = sdhe_pkg::ARG_HCS;
                        dc_next = P_ACMD41;
                     end
                     P_ACMD41: begin
                        do_cmd = 1'b1;
                        if (dbyte != 8'd0 && retry_ff != 16'd0) begin
                           retry_in = retry_ff - 16'd1;
                           dc_next  = P_ACMD55;
                        end else begin
                           init_ok_in = (dbyte == 8'd0);
                           dc_code    = sdhe_pkg::CMD_READ_OCR;
                           dc_next    = P_CMD58;
                        end
                     end
                     P_CMD58: begin
                        if (dbyte == 8'd0) begin
                           bcount_in = '0;
                           phase_in  = P_OCR;
                           o_valid   = 1'b1;
                        end else begin
                           do_fin = 1'b1;
                           fin_st = init_ok_ff ? sdhe_pkg::ST_OK : sdhe_pkg::ST_INIT_FAIL;
                        end
                     end
                     P_CMD17: begin
                        if (dbyte != 8'd0) begin
                           do_fin = 1'b1;
                           fin_st = sdhe_pkg::ST_CMD_REJ;
                        end else begin
                           retry_in = 16'(TOKEN_WAIT_LIMIT);
                           phase_in = P_TOKEN;
                           o_valid  = 1'b1;
                        end
                     end
                     P_W55: begin
                        do_cmd  = 1'b1;
                        dc_code = sdhe_pkg::CMD_SET_COUNT;
                        dc_arg  = 32'd1;
                        dc_next = P_W23;
                     end
                     P_W23: begin
                        do_cmd  = 1'b1;
                        dc_code = sdhe_pkg::CMD_WRITE_BLK;
                        dc_arg  = card_addr_ff;
                        dc_next = P_W24;
                     end
                     P_W24: begin
                        if (dbyte != 8'd0) begin
                           do_fin = 1'b1;
                           fin_st = sdhe_pkg::ST_CMD_REJ;
                        end else begin
                           bcount_in = '0;
                           phase_in  = P_WSEND;
                           o_valid   = 1'b1;
                        end
                     end
                     default: begin
                        do_fin = 1'b1;
                        fin_st = sdhe_pkg::ST_CMD_REJ;
                     end
                  endcase
               end
            end else if (phase_ff != P_IDLE) begin
               unique case (phase_ff)
                  P_CLK: begin
                     if (bcount_ff <= 10'(IDLE_CLOCK_BYTES)) begin
                        bcount_in = bc_inc;
                        o_valid   = 1'b1;
                        o_cs      = 1'b1;
                     end else begin
                        retry_in = 16'(CMD0_RETRIES);
                        do_cmd   = 1'b1;
                        dc_code  = sdhe_pkg::CMD_GO_IDLE;
                        dc_crc   = sdhe_pkg::CRC_CMD0;
                        dc_next  = P_CMD0;
                     end
                  end
                  P_CMD0_DS: begin
                     if (last_r1_ff == 8'h01) begin
                        do_cmd  = 1'b1;
                        dc_code = sdhe_pkg::CMD_SEND_IF;
                        dc_arg  = sdhe_pkg::ARG_IF_COND;
                        dc_crc  = sdhe_pkg::CRC_CMD8;
                        dc_next = P_CMD8;
                     end else if (retry_ff != 16'd0) begin
                        retry_in = retry_ff - 16'd1;
                        do_cmd   = 1'b1;
                        dc_code  = sdhe_pkg::CMD_GO_IDLE;
                        dc_crc   = sdhe_pkg::CRC_CMD0;
                        dc_next  = P_CMD0;
                     end else begin
                        init_ok_in = 1'b0;
                        do_fin     = 1'b1;
                        fin_st     = sdhe_pkg::ST_NO_IDLE;
                     end
                  end
                  P_OCR: begin
                     // first OCR byte carries the capacity bit
                     if (bcount_ff == 10'd0) begin
                        ccs_in = dbyte[6];
                     end
                     bcount_in = bc_inc;
                     o_valid   = 1'b1;
                     if (bc_inc >= 10'd4) begin
                        det_type_in = ccs_in ? sdhe_pkg::CARD_SDHC_V2
                                             : sdhe_pkg::CARD_SDSC_V2;
                        phase_in    = P_OCR_DS;
                        o_cs        = 1'b1;
                     end
                  end
                  P_OCR_DS: begin
                     do_fin = 1'b1;
                     fin_st = init_ok_ff ? sdhe_pkg::ST_OK : sdhe_pkg::ST_INIT_FAIL;
                  end
                  P_TOKEN: begin
                     if (dbyte == sdhe_pkg::DATA_TOKEN) begin
                        bcount_in = '0;
                        phase_in  = P_RDATA;
                        o_valid   = 1'b1;
                     end else if (retry_ff != 16'd0) begin
                        retry_in = retry_ff - 16'd1;
                        o_valid  = 1'b1;
                     end else begin
                        do_fin = 1'b1;
                        fin_st = sdhe_pkg::ST_TOKEN_TO;
                     end
                  end
                  P_RDATA: begin
                     o_rdv     = 1'b1;
                     o_rdb     = dbyte;
                     o_valid   = 1'b1;
                     bcount_in = bc_inc;
                     if (bc_inc >= 10'(sdhe_pkg::BLOCK_BYTES)) begin
                        bcount_in = '0;
                        phase_in  = P_RCRC;
                     end
                  end
                  P_RCRC: begin
                     if (bcount_ff == 10'd0) begin
                        bcount_in = 10'd1;
                        o_valid   = 1'b1;
                     end else begin
                        do_fin = 1'b1;
                     end
                  end
                  P_WSEND: begin
                     if (bcount_ff < 10'(sdhe_pkg::BLOCK_BYTES + 6)) begin
                        // three fill bytes, start token, data block, CRC fill
                        bcount_in = bc_inc;
                        o_valid   = 1'b1;
                        wpos      = bc_inc - 10'd4;
                        if (bc_inc == 10'd3) begin
                           o_tx = sdhe_pkg::DATA_TOKEN;
                        end else if (bc_inc > 10'd3 &&
                                     bc_inc < 10'(sdhe_pkg::BLOCK_BYTES + 4)) begin
                           o_use_ram = 1'b1;
                           ram_raddr = wpos[sdhe_pkg::BLOCK_AW-1:0];
                        end
                     end else if (dbyte[4:0] != sdhe_pkg::DRESP_OK) begin
                        do_fin = 1'b1;
                        fin_st = sdhe_pkg::ST_WRITE_ERR;
                     end else begin
                        retry_in = '0;
                        phase_in = P_BUSY;
                        o_valid  = 1'b1;
                     end
                  end
                  P_BUSY: begin
                     if (dbyte != 8'd0) begin
                        do_fin = 1'b1;
                     end else begin
                        retry_in = retry_ff + 16'd1;
                        if (retry_ff == 16'hFFFE) begin
                           do_fin = 1'b1;
                           fin_st = sdhe_pkg::ST_WRITE_ERR;
                        end else begin
                           o_valid = 1'b1;
                        end
                     end
                  end
                  P_FINISH: begin
                     phase_in = P_IDLE;
                     if (op_init_ff) begin
                        fast_in = 1'b1;
                     end
                     o_valid = 1'b1;
                     o_txv   = 1'b0;
                     o_tx    = 8'd0;
                     o_cs    = 1'b1;
                     o_done  = 1'b1;
                     o_st    = end_st_ff;
                  end
                  default: begin
                     o_valid = 1'b0;
                  end
               endcase
            end
         end
         default: begin
            o_valid = 1'b0;
         end
      endcase

      // launch a command: deselected fill byte, then the frame
      if (do_cmd) begin
         cmd_code_in  = dc_code;
         cmd_arg_in   = dc_arg;
         cmd_crc_in   = dc_crc;
         cmd_busy_in  = 1'b1;
         cmd_pos_in   = '0;
         cmd_polls_in = '0;
         phase_in     = dc_next;
         o_valid      = 1'b1;
         o_cs         = 1'b1;
      end
      // end an operation: one deselect byte before the done result
      if (do_fin) begin
         end_st_in = fin_st;
         phase_in  = P_FINISH;
         o_valid   = 1'b1;
         o_cs      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= P_IDLE;
         retry_ff     <= '0;
         bcount_ff    <= '0;
         last_r1_ff   <= sdhe_pkg::IDLE_BYTE;
         det_type_ff  <= sdhe_pkg::CARD_UNKNOWN;
         card_addr_ff <= '0;
         init_ok_ff   <= 1'b0;
         fast_ff      <= 1'b0;
         op_init_ff   <= 1'b0;
         ccs_ff       <= 1'b0;
         end_st_ff    <= sdhe_pkg::ST_OK;
         cmd_busy_ff  <= 1'b0;
         cmd_pos_ff   <= '0;
         cmd_polls_ff <= '0;
         cmd_code_ff  <= '0;
         cmd_arg_ff   <= '0;
         cmd_crc_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            retry_ff     <= retry_in;
            bcount_ff    <= bcount_in;
            last_r1_ff   <= last_r1_in;
            det_type_ff  <= det_type_in;
            card_addr_ff <= card_addr_in;
            init_ok_ff   <= init_ok_in;
            fast_ff      <= fast_in;
            op_init_ff   <= op_init_in;
            ccs_ff       <= ccs_in;
            end_st_ff    <= end_st_in;
            cmd_busy_ff  <= cmd_busy_in;
            cmd_pos_ff   <= cmd_pos_in;
            cmd_polls_ff <= cmd_polls_in;
            cmd_code_ff  <= cmd_code_in;
            cmd_arg_ff   <= cmd_arg_in;
            cmd_crc_ff   <= cmd_crc_in;
         end
         // load a new result, else drop the one just taken
         if (accept && o_valid) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept && o_valid) begin
         txv_ff     <= o_txv;
         tx_ff      <= o_tx;
         use_ram_ff <= o_use_ram;
         cs_ff      <= o_cs;
         fastq_ff   <= fast_in;
         rdv_ff     <= o_rdv;
         rdb_ff     <= o_rdb;
         done_ff    <= o_done;
         st_ff      <= o_st;
         ctype_ff   <= det_type_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, ctype_ff, st_ff, done_ff, rdb_ff, rdv_ff, fastq_ff, cs_ff,
                        (use_ram_ff ? ram_q : tx_ff), txv_ff};

endmodule

`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: SD card SPI host engine
// Plays an emulated card against the engine: starts init, block reads and
// block writes, answers every SPI byte the engine names, and checks each rsp
// transaction against an in-bench predictor of the byte sequencer. Covers
// failing and timing-out cards, back-pressure and random sender/receiver gaps.
// ----------------------------------------------------------------------------
module testbench;
   import sdhe_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   // predictor phases of the engine
   typedef enum logic [4:0] {
      PH_IDLE, PH_CLK, PH_CMD0, PH_CMD0_DS, PH_CMD8, PH_ACMD55, PH_ACMD41, PH_CMD58,
      PH_OCR, PH_OCR_DS, PH_CMD17, PH_TOKEN, PH_RDATA, PH_RCRC, PH_W55, PH_W23,
      PH_W24, PH_WSEND, PH_BUSY, PH_FINISH
   } phase_e;

   // behavior of the emulated card
   typedef enum logic [2:0] {
      EMU_GOOD, EMU_SLOW, EMU_DEAD, EMU_BAD_IF, EMU_REJECT, EMU_BAD_DRESP,
      EMU_NO_TOKEN, EMU_STUCK_BUSY
   } card_mode_e;

   // rsp fields, highest bits first so the struct overlays rsp_tdata[25:0]
   typedef struct packed {
      logic [1:0] card_type;
      logic [2:0] status;
      logic       done;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       fast_clock;
      logic       cs_n;
      logic [7:0] tx_byte;
      logic       tx_valid;
   } rsp_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   sd_card_spi_host_engine u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // ------------------------------------------------------------------------
   // Predicted engine state
   // ------------------------------------------------------------------------
   phase_e      ph;
   int unsigned retries;
   int unsigned count;
   logic [7:0]  last_resp;
   logic [1:0]  ctype;
   logic [31:0] addr;
   logic        init_ok;
   logic [7:0]  wbuf [BLOCK_BYTES];
   logic        fast_on;
   logic        op_is_init;
   logic        hc_flag;
   logic [2:0]  fin_status;
   logic        cmd_active;
   int unsigned cmd_pos;
   int unsigned poll_n;
   logic [5:0]  cmd_op;
   logic [31:0] cmd_arg32;
   logic [7:0]  cmd_crc8;
   logic        rdv;
   logic [7:0]  rdb;

   rsp_t        expected_rsp_q[$];

   // test control
   card_mode_e  emu;
   int          ocr_pref;     // 0 standard capacity, 1 high capacity, 2 random
   bit          idle_on;
   bit          rx_free;
   int          hold_req;
   int          hold_left;
   int          burst_left;
   int          items_sent;
   int          errors;
   int          cycles;
   logic [15:0] stall_pat;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic void push_rsp(logic txv, logic [7:0] tx, logic cs, logic done,
                                    logic [2:0] st);
      rsp_t r;
      r.tx_valid   = txv;
      r.tx_byte    = tx;
      r.cs_n       = cs;
      r.fast_clock = fast_on;
      r.read_valid = rdv;
      r.read_byte  = rdv ? rdb : 8'h00;
      r.done       = done;
      r.status     = st;
      r.card_type  = ctype;
      expected_rsp_q.push_back(r);
   endfunction

   function automatic void emit_byte(logic [7:0] tx, logic cs);
      push_rsp(1'b1, tx, cs, 1'b0, ST_OK);
   endfunction

   // deselect byte first, the done transaction follows on its reply
   function automatic void finish_op(logic [2:0] st);
      fin_status = st;
      ph = PH_FINISH;
      emit_byte(IDLE_BYTE, 1'b1);
   endfunction

   function automatic void issue_cmd(logic [5:0] op, logic [31:0] arg, logic [7:0] crc,
                                     phase_e nxt);
      cmd_op     = op;
      cmd_arg32  = arg;
      cmd_crc8   = crc;
      cmd_active = 1'b1;
      cmd_pos    = 0;
      poll_n     = 0;
      ph         = nxt;
      emit_byte(IDLE_BYTE, 1'b1);
   endfunction

   function automatic logic [7:0] frame_byte(int unsigned pos);
      case (pos)
         1: return {2'b01, cmd_op};
         2: return cmd_arg32[31:24];
         3: return cmd_arg32[23:16];
         4: return cmd_arg32[15:8];
         5: return cmd_arg32[7:0];
         6: return cmd_crc8;
         default: return IDLE_BYTE;
      endcase
   endfunction

   // byte stream of a block write: three fillers, token, block, CRC fillers
   function automatic logic [7:0] block_write_byte(int unsigned p);
      if (p < 3) return IDLE_BYTE;
      if (p == 3) return DATA_TOKEN;
      if (p < 4 + BLOCK_BYTES) return wbuf[p - 4];
      return IDLE_BYTE;
   endfunction

   function automatic void command_answered(logic [7:0] r);
      case (ph)
         PH_CMD0: begin
            ph = PH_CMD0_DS;
            emit_byte(IDLE_BYTE, 1'b1);
         end
         PH_CMD8: begin
            if (r == 8'h01) begin
               retries = DEF_ACMD41_RETRIES;
               issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, PH_ACMD55);
            end else begin
               init_ok = 1'b0;
               finish_op(ST_INIT_FAIL);
            end
         end
         PH_ACMD55: issue_cmd(CMD_SD_OP_COND, ARG_HCS, CRC_DUMMY, PH_ACMD41);
         PH_ACMD41: begin
            if (r != 8'h00 && retries != 0) begin
               retries--;
               issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, PH_ACMD55);
            end else begin
               init_ok = (r == 8'h00);
               issue_cmd(CMD_READ_OCR, 32'd0, CRC_DUMMY, PH_CMD58);
            end
         end
         PH_CMD58: begin
            if (r == 8'h00) begin
               count = 0;
               ph = PH_OCR;
               emit_byte(IDLE_BYTE, 1'b0);
            end else begin
               finish_op(init_ok ? ST_OK : ST_INIT_FAIL);
            end
         end
         PH_CMD17: begin
            if (r != 8'h00) begin
               finish_op(ST_CMD_REJ);
            end else begin
               retries = DEF_TOKEN_WAIT_LIMIT;
               ph = PH_TOKEN;
               emit_byte(IDLE_BYTE, 1'b0);
            end
         end
         PH_W55: issue_cmd(CMD_SET_COUNT, 32'd1, CRC_DUMMY, PH_W23);
         PH_W23: issue_cmd(CMD_WRITE_BLK, addr, CRC_DUMMY, PH_W24);
         PH_W24: begin
            if (r != 8'h00) begin
               finish_op(ST_CMD_REJ);
            end else begin
               count = 0;
               ph = PH_WSEND;
               emit_byte(block_write_byte(0), 1'b0);
            end
         end
         default: finish_op(ST_CMD_REJ);
      endcase
   endfunction

   function automatic void card_replied(logic [7:0] d);
      if (cmd_active) begin
         if (cmd_pos < 7) begin
            cmd_pos++;
            emit_byte(frame_byte(cmd_pos), 1'b0);
         end else if (d[7] && poll_n < DEF_R1_POLL_LIMIT) begin
            poll_n++;
            emit_byte(IDLE_BYTE, 1'b0);
         end else begin
            cmd_active = 1'b0;
            last_resp = d;
            command_answered(d);
         end
         return;
      end
      case (ph)
         PH_CLK: begin
            if (count <= DEF_IDLE_CLOCK_BYTES) begin
               count++;
               emit_byte(IDLE_BYTE, 1'b1);
            end else begin
               retries = DEF_CMD0_RETRIES;
               issue_cmd(CMD_GO_IDLE, 32'd0, CRC_CMD0, PH_CMD0);
            end
         end
         PH_CMD0_DS: begin
            if (last_resp == 8'h01) begin
               issue_cmd(CMD_SEND_IF, ARG_IF_COND, CRC_CMD8, PH_CMD8);
            end else if (retries != 0) begin
               retries--;
               issue_cmd(CMD_GO_IDLE, 32'd0, CRC_CMD0, PH_CMD0);
            end else begin
               init_ok = 1'b0;
               finish_op(ST_NO_IDLE);
            end
         end
         PH_OCR: begin
            if (count == 0) hc_flag = d[6];
            count++;
            if (count < 4) begin
               emit_byte(IDLE_BYTE, 1'b0);
            end else begin
               ctype = hc_flag ? CARD_SDHC_V2 : CARD_SDSC_V2;
               ph = PH_OCR_DS;
               emit_byte(IDLE_BYTE, 1'b1);
            end
         end
         PH_OCR_DS: finish_op(init_ok ? ST_OK : ST_INIT_FAIL);
         PH_TOKEN: begin
            if (d == DATA_TOKEN) begin
               count = 0;
               ph = PH_RDATA;
               emit_byte(IDLE_BYTE, 1'b0);
            end else if (retries != 0) begin
               retries--;
               emit_byte(IDLE_BYTE, 1'b0);
            end else begin
               finish_op(ST_TOKEN_TO);
            end
         end
         PH_RDATA: begin
            rdv = 1'b1;
            rdb = d;
            count++;
            if (count >= BLOCK_BYTES) begin
               count = 0;
               ph = PH_RCRC;
            end
            emit_byte(IDLE_BYTE, 1'b0);
         end
         PH_RCRC: begin
            if (count == 0) begin
               count = 1;
               emit_byte(IDLE_BYTE, 1'b0);
            end else begin
               finish_op(ST_OK);
            end
         end
         PH_WSEND: begin
            if (count < BLOCK_BYTES + 6) begin
               count++;
               emit_byte(block_write_byte(count), 1'b0);
            end else if (d[4:0] != DRESP_OK) begin
               finish_op(ST_WRITE_ERR);
            end else begin
               retries = 0;
               ph = PH_BUSY;
               emit_byte(IDLE_BYTE, 1'b0);
            end
         end
         PH_BUSY: begin
            if (d != 8'h00) begin
               finish_op(ST_OK);
            end else begin
               retries++;
               if (retries > 32'hFFFE) finish_op(ST_WRITE_ERR);
               else emit_byte(IDLE_BYTE, 1'b0);
            end
         end
         PH_FINISH: begin
            ph = PH_IDLE;
            if (op_is_init) fast_on = 1'b1;
            push_rsp(1'b0, 8'h00, 1'b1, 1'b1, fin_status);
         end
         default: ;
      endcase
   endfunction

   function automatic void predict_engine(logic [2:0] k, logic [31:0] sec, logic [7:0] d,
                                          logic [8:0] idx);
      rdv = 1'b0;
      rdb = 8'h00;
      case (k)
         KIND_INIT: begin
            if (ph == PH_IDLE) begin
               op_is_init = 1'b1;
               fast_on = 1'b0;
               ctype = CARD_UNKNOWN;
               init_ok = 1'b0;
               count = 1;
               ph = PH_CLK;
               emit_byte(IDLE_BYTE, 1'b1);
            end
         end
         KIND_READ, KIND_WRITE: begin
            if (ph == PH_IDLE) begin
               op_is_init = 1'b0;
               addr = (ctype == CARD_SDHC_V2) ? sec : (sec << 9);
               if (k == KIND_READ) issue_cmd(CMD_READ_BLK, addr, CRC_DUMMY, PH_CMD17);
               else issue_cmd(CMD_APP, 32'd0, CRC_DUMMY, PH_W55);
            end
         end
         KIND_LOAD: wbuf[idx] = d;
         KIND_REPLY: if (ph != PH_IDLE) card_replied(d);
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Emulated card: picks the byte the card shifts back for the next exchange
   // ------------------------------------------------------------------------
   function automatic logic [7:0] command_r1();
      case (ph)
         PH_CMD0:   return ($urandom_range(0, 7) != 0) ? 8'h01 : 8'($urandom_range(0, 127));
         PH_CMD8: begin
            if (emu == EMU_BAD_IF) return 8'h05;
            return ($urandom_range(0, 9) != 0) ? 8'h01 : 8'($urandom_range(0, 127));
         end
         PH_ACMD41: return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'h01;
         PH_CMD58:  return ($urandom_range(0, 7) != 0) ? 8'h00 : 8'($urandom_range(0, 127));
         PH_CMD17, PH_W24: begin
            if (emu == EMU_REJECT) return 8'($urandom_range(1, 127));
            return ($urandom_range(0, 7) != 0) ? 8'h00 : 8'($urandom_range(1, 127));
         end
         default:   return 8'($urandom_range(0, 127));
      endcase
   endfunction

   function automatic logic [7:0] card_byte();
      logic [7:0] b;
      if (emu == EMU_DEAD) return IDLE_BYTE;
      if (cmd_active) begin
         if (cmd_pos < 7) return 8'($urandom);
         if (emu == EMU_SLOW) return ($urandom_range(0, 40) != 0) ? IDLE_BYTE : command_r1();
         return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255)) : command_r1();
      end
      case (ph)
         PH_OCR: begin
            b = 8'($urandom);
            if (count == 0 && ocr_pref != 2) b[6] = (ocr_pref == 1);
            return b;
         end
         PH_TOKEN: begin
            if (emu == EMU_NO_TOKEN) return IDLE_BYTE;
            return ($urandom_range(0, 3) == 0) ? DATA_TOKEN : IDLE_BYTE;
         end
         PH_WSEND: begin
            b = 8'($urandom);
            if (count < BLOCK_BYTES + 6) return b;
            if (emu == EMU_BAD_DRESP) begin
               if (b[4:0] == DRESP_OK) b[3] = 1'b1;
               return b;
            end
            return {b[7:5], DRESP_OK};
         end
         PH_BUSY: begin
            if (emu == EMU_STUCK_BUSY) return 8'h00;
            return ($urandom_range(0, 3) != 0) ? 8'h00 : 8'($urandom_range(1, 255));
         end
         default: return 8'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Clock, reset, cycle limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: stall pattern, long hold-off on request, and result checking
   // ------------------------------------------------------------------------
   function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         errors++;
         $display("%0t: rsp %s mismatch, expected 0x%0h, actual 0x%0h",
                  $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      rsp_t exp_r;
      rsp_t act_r;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_pat <= 16'hFFFF;
      end else begin
         // check the transaction taken at this edge against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            act_r = rsp_t'(rsp_tdata[25:0]);
            if (expected_rsp_q.size() == 0) begin
               errors++;
               $display("%0t: rsp transaction with nothing expected, actual 0x%0h",
                        $time, rsp_tdata);
            end else begin
               exp_r = expected_rsp_q.pop_front();
               check_field("tx_valid", exp_r.tx_valid, act_r.tx_valid);
               check_field("tx_byte", exp_r.tx_byte, act_r.tx_byte);
               check_field("chip_select_n", exp_r.cs_n, act_r.cs_n);
               check_field("fast_clock", exp_r.fast_clock, act_r.fast_clock);
               check_field("read_valid", exp_r.read_valid, act_r.read_valid);
               check_field("read_byte", exp_r.read_byte, act_r.read_byte);
               check_field("done", exp_r.done, act_r.done);
               check_field("status", exp_r.status, act_r.status);
               check_field("card_type", exp_r.card_type, act_r.card_type);
            end
         end
         if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
         end
         // hold off, free run, or follow the rotating stall pattern
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= rx_free | stall_pat[0];
         end
         if (cycles % 200 == 0) begin
            stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
         end else begin
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------------
   // drive one transaction, wait for its handshake, then predict and maybe rest
   task automatic send_item(logic [2:0] k, logic [31:0] sec, logic [7:0] d, logic [8:0] idx);
      req_tvalid <= 1'b1;
      req_tuser  <= k;
      req_tdata  <= {7'd0, idx, d, sec};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      predict_engine(k, sec, d, idx);
      items_sent++;
      if (idle_on) begin
         if (burst_left == 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(0, 24);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_item(3'($urandom_range(KIND_INIT, KIND_WRITE)), $urandom, 8'($urandom),
                      9'($urandom));
         1: send_item(3'($urandom_range(5, 7)), $urandom, 8'($urandom), 9'($urandom));
         default: send_item(KIND_LOAD, $urandom, 8'($urandom), 9'($urandom));
      endcase
   endtask

   // start an operation and answer as the card until the done transaction
   task automatic run_op(logic [2:0] k, logic [31:0] sec, bit noisy);
      send_item(k, sec, 8'($urandom), 9'($urandom));
      while (ph != PH_IDLE) begin
         if (noisy && $urandom_range(0, 11) == 0) send_noise();
         else send_item(KIND_REPLY, $urandom, card_byte(), 9'($urandom));
      end
   endtask

   // drop the request line while waiting so no transaction is offered twice
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      wait (expected_rsp_q.size() == 0);
      @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // ignored items while idle; fill the whole write buffer
   task automatic test_idle_items();
      int i;
      send_item(KIND_REPLY, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
      send_item(3'd5, 32'd0, 8'h00, 9'd0);
      send_item(3'd6, $urandom, 8'($urandom), 9'($urandom));
      send_item(3'd7, 32'hFFFF_FFFF, 8'hFF, 9'h1FF);
      for (i = 0; i < BLOCK_BYTES; i++) begin
         send_item(KIND_LOAD, $urandom, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom),
                   9'(i));
      end
   endtask

   task automatic test_init_failures();
      emu = EMU_DEAD;
      run_op(KIND_INIT, 32'd0, 1'b0);
      emu = EMU_BAD_IF;
      run_op(KIND_INIT, 32'd0, 1'b0);
   endtask

   // both card types, sector extremes, starts while busy
   task automatic test_good_card();
      emu = EMU_GOOD;
      ocr_pref = 0;
      run_op(KIND_INIT, 32'd0, 1'b1);
      run_op(KIND_READ, 32'hFFFF_FFFF, 1'b1);
      run_op(KIND_WRITE, 32'h0080_0001, 1'b1);
      ocr_pref = 1;
      run_op(KIND_INIT, 32'd0, 1'b0);
      run_op(KIND_READ, 32'hFFFF_FFFF, 1'b0);
      run_op(KIND_WRITE, 32'd0, 1'b0);
      emu = EMU_SLOW;
      run_op(KIND_READ, 32'h1234_5678, 1'b0);
   endtask

   task automatic test_rejects();
      emu = EMU_REJECT;
      run_op(KIND_READ, $urandom, 1'b0);
      run_op(KIND_WRITE, $urandom, 1'b0);
      emu = EMU_BAD_DRESP;
      run_op(KIND_WRITE, $urandom, 1'b0);
   endtask

   // token and busy timeouts are long: run them at full rate
   task automatic test_timeouts();
      idle_on = 1'b0;
      rx_free = 1'b1;
      emu = EMU_NO_TOKEN;
      run_op(KIND_READ, $urandom, 1'b0);
      emu = EMU_STUCK_BUSY;
      run_op(KIND_WRITE, $urandom, 1'b0);
      rx_free = 1'b0;
      idle_on = 1'b1;
   endtask

   // stall the receiver long enough for the engine to block its input
   task automatic test_backpressure();
      emu = EMU_GOOD;
      idle_on = 1'b0;
      hold_req = 300;
      run_op(KIND_READ, $urandom, 1'b0);
      idle_on = 1'b1;
      wait_drained();
   endtask

   task automatic test_random();
      int pick;
      logic [31:0] sec;
      int start_items;
      start_items = items_sent;
      while (items_sent - start_items < 1300) begin
         pick = $urandom_range(0, 99);
         emu = (pick < 80) ? EMU_GOOD : card_mode_e'($urandom_range(EMU_SLOW, EMU_BAD_DRESP));
         ocr_pref = 2;
         sec = ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
         case ($urandom_range(0, 2))
            0: run_op(KIND_INIT, sec, 1'b1);
            1: run_op(KIND_READ, sec, 1'b1);
            default: run_op(KIND_WRITE, sec, 1'b1);
         endcase
         if ($urandom_range(0, 2) == 0) send_item(KIND_REPLY, $urandom, 8'($urandom),
                                                   9'($urandom));
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid <= 1'b0;
      req_tuser <= KIND_INIT;
      req_tdata <= '0;
      cycles = 0;
      errors = 0;
      items_sent = 0;
      hold_req = 0;
      hold_left = 0;
      burst_left = 0;
      idle_on = 1'b1;
      rx_free = 1'b0;
      emu = EMU_GOOD;
      ocr_pref = 2;
      // predictor reset state
      ph = PH_IDLE;
      retries = 0;
      count = 0;
      last_resp = 8'hFF;
      ctype = CARD_UNKNOWN;
      addr = '0;
      init_ok = 1'b0;
      fast_on = 1'b0;
      op_is_init = 1'b0;
      hc_flag = 1'b0;
      fin_status = ST_OK;
      cmd_active = 1'b0;
      cmd_pos = 0;
      poll_n = 0;
      cmd_op = '0;
      cmd_arg32 = '0;
      cmd_crc8 = '0;
      rdv = 1'b0;
      rdb = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_idle_items();
      test_init_failures();
      test_good_card();
      test_rejects();
      test_timeouts();
      test_backpressure();
      test_random();

      wait_drained();
      repeat (10) @(posedge clock);
      if (errors == 0 && expected_rsp_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/sdhe_pkg.sv
rtl/core/sdhe_ram.sv
rtl/core/sd_card_spi_host_engine.sv
test/testbench.sv
